@@ hw/rtl/mscl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscl_pkg
// Shared types and constants for the Morton-sorted cell lookup block.
// ----------------------------------------------------------------------------
package mscl_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_COORD_BITS  = 10;

    localparam int IN_COORD_W  = 11;
    localparam int OUT_COORD_W = 10;
    localparam int IDX_W       = 10;
    localparam int LVL_W       = 4;
    localparam int FUNC_W      = 2;
    localparam int MORTON_W    = 3 * IN_COORD_W;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SRCH,
        ST_CHK0,
        ST_CHK1,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic ld_in;
        logic clr;
        logic app;
        logic srch_init;
        logic srch_step;
        logic chk0;
        logic chk1;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              neg;
        logic              empty;
        logic              srch_done;
        logic              past_end;
        logic              contain;
        logic              lo_zero;
        logic              out_free;
    } t_stat;

endpackage

@@ hw/rtl/mscl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscl_ctrl
// Sequencer for clear, append and the binary search with containment checks.
// ----------------------------------------------------------------------------
module mscl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mscl_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output mscl_pkg::t_cmd  o_cmd
);
    import mscl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_stat.func)
                    FUNC_QUERY: begin
                        if (i_stat.neg || i_stat.empty) begin
                            n_state = ST_FIN;
                        end else begin
                            n_state = ST_SRCH;
                        end
                    end
                    default: n_state = ST_FIN;
                endcase
            end
            ST_SRCH: begin
                if (i_stat.srch_done) begin
                    n_state = i_stat.past_end ? ST_FIN : ST_CHK0;
                end
            end
            ST_CHK0: begin
                if (i_stat.contain || i_stat.lo_zero) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_CHK1;
                end
            end
            ST_CHK1: n_state = ST_FIN;
            ST_FIN: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.ld_in  = i_valid;
            end
            ST_DECODE: begin
                unique case (i_stat.func)
                    FUNC_CLEAR:  o_cmd.clr = 1'b1;
                    FUNC_APPEND: o_cmd.app = 1'b1;
                    FUNC_QUERY:  o_cmd.srch_init = !(i_stat.neg || i_stat.empty);
                    default:     o_cmd = '0;
                endcase
            end
            ST_SRCH: o_cmd.srch_step = 1'b1;
            ST_CHK0: o_cmd.chk0 = 1'b1;
            ST_CHK1: o_cmd.chk1 = 1'b1;
            ST_FIN:  o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ hw/rtl/mscl_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscl_dp
// Cell table memory, search registers, containment compare and result register.
// ----------------------------------------------------------------------------
module mscl_dp #(
    parameter int TABLE_DEPTH = mscl_pkg::DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = mscl_pkg::DEF_COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mscl_pkg::t_cmd                    i_cmd,
    output mscl_pkg::t_stat                   o_stat,
    input  logic [mscl_pkg::FUNC_W-1:0]       i_func,
    input  logic signed [mscl_pkg::IN_COORD_W-1:0] i_coord_x,
    input  logic signed [mscl_pkg::IN_COORD_W-1:0] i_coord_y,
    input  logic signed [mscl_pkg::IN_COORD_W-1:0] i_coord_z,
    input  logic [mscl_pkg::LVL_W-1:0]        i_cell_level,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic                              o_found,
    output logic [mscl_pkg::IDX_W-1:0]        o_hit_index,
    output logic [mscl_pkg::OUT_COORD_W-1:0]  o_hit_x,
    output logic [mscl_pkg::OUT_COORD_W-1:0]  o_hit_y,
    output logic [mscl_pkg::OUT_COORD_W-1:0]  o_hit_z,
    output logic [mscl_pkg::LVL_W-1:0]        o_hit_level,
    output logic                              o_status
);
    import mscl_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
    localparam int EW = 3 * SW + LVL_W;

    function automatic logic [MORTON_W-1:0] morton3(
        input logic [IN_COORD_W-1:0] x,
        input logic [IN_COORD_W-1:0] y,
        input logic [IN_COORD_W-1:0] z
    );
        logic [MORTON_W-1:0] m;
        m = '0;
        for (int i = 0; i < IN_COORD_W; i++) begin
            m[3*i]     = x[i];
            m[3*i + 1] = y[i];
            m[3*i + 2] = z[i];
        end
        return m;
    endfunction

    logic [EW-1:0] r_mem [TABLE_DEPTH];
    logic [EW-1:0] r_rdata;
    logic [AW-1:0] rd_addr;

    logic [FUNC_W-1:0]     r_func;
    logic [IN_COORD_W-1:0] r_qx, r_qy, r_qz;
    logic [LVL_W-1:0]      r_qlv;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_lo, r_hi;
    logic [AW-1:0]         r_mid;

    logic                   r_found, r_status;
    logic [IDX_W-1:0]       r_idx;
    logic [OUT_COORD_W-1:0] r_hx, r_hy, r_hz;
    logic [LVL_W-1:0]       r_hlv;

    logic                   r_o_valid, r_o_found, r_o_status;
    logic [IDX_W-1:0]       r_o_idx;
    logic [OUT_COORD_W-1:0] r_o_x, r_o_y, r_o_z;
    logic [LVL_W-1:0]       r_o_lv;

    logic [IN_COORD_W-1:0] cx, cy, cz;
    logic [LVL_W-1:0]      clv, shamt;
    logic                  lt, contain, full;
    logic [CW-1:0]         mid_w, mid_p1, n_mid_lt, n_mid_ge, n_lo, n_hi, lo_m1;
    logic                  srch_done;

    assign cx  = IN_COORD_W'(r_rdata[SW-1:0]);
    assign cy  = IN_COORD_W'(r_rdata[2*SW-1:SW]);
    assign cz  = IN_COORD_W'(r_rdata[3*SW-1:2*SW]);
    assign clv = r_rdata[EW-1:3*SW];

    assign lt = morton3(cx, cy, cz) < morton3(r_qx, r_qy, r_qz);

    assign shamt   = (clv > r_qlv) ? clv : r_qlv;
    assign contain = ((cx >> shamt) == (r_qx >> shamt)) &&
                     ((cy >> shamt) == (r_qy >> shamt)) &&
                     ((cz >> shamt) == (r_qz >> shamt));

    assign full = (r_count == CW'(TABLE_DEPTH));

    // candidate midpoints for both compare outcomes
    assign mid_w    = CW'(r_mid);
    assign mid_p1   = mid_w + CW'(1);
    assign n_mid_lt = mid_p1 + ((r_hi - mid_p1) >> 1);
    assign n_mid_ge = r_lo + ((mid_w - r_lo) >> 1);
    assign n_lo     = lt ? mid_p1 : r_lo;
    assign n_hi     = lt ? r_hi : mid_w;
    assign srch_done = lt ? (mid_p1 == r_hi) : (mid_w == r_lo);
    assign lo_m1    = r_lo - CW'(1);

    always_comb begin
        rd_addr = r_mid;
        if (i_cmd.srch_init) begin
            rd_addr = AW'(r_count >> 1);
        end else if (i_cmd.srch_step) begin
            if (srch_done) begin
                rd_addr = AW'(n_lo);
            end else begin
                rd_addr = lt ? AW'(n_mid_lt) : AW'(n_mid_ge);
            end
        end else if (i_cmd.chk0) begin
            rd_addr = AW'(lo_m1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.app && !full) begin
            r_mem[AW'(r_count)] <= {r_qlv, SW'(r_qz), SW'(r_qy), SW'(r_qx)};
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clr) begin
            r_count <= '0;
        end else if (i_cmd.app && !full) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_func   <= i_func;
            r_qx     <= i_coord_x;
            r_qy     <= i_coord_y;
            r_qz     <= i_coord_z;
            r_qlv    <= i_cell_level;
            r_found  <= 1'b0;
            r_status <= 1'b0;
            r_idx    <= '0;
            r_hx     <= '0;
            r_hy     <= '0;
            r_hz     <= '0;
            r_hlv    <= '0;
        end
        if (i_cmd.app && full) begin
            r_status <= 1'b1;
        end
        if (i_cmd.srch_init) begin
            r_lo  <= '0;
            r_hi  <= r_count;
            r_mid <= AW'(r_count >> 1);
        end
        if (i_cmd.srch_step) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= lt ? AW'(n_mid_lt) : AW'(n_mid_ge);
        end
        if ((i_cmd.chk0 || i_cmd.chk1) && contain) begin
            r_found <= 1'b1;
            r_idx   <= i_cmd.chk0 ? IDX_W'(r_lo) : IDX_W'(lo_m1);
            r_hx    <= OUT_COORD_W'(cx);
            r_hy    <= OUT_COORD_W'(cy);
            r_hz    <= OUT_COORD_W'(cz);
            r_hlv   <= clv;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_found  <= r_found;
            r_o_status <= r_status;
            r_o_idx    <= r_idx;
            r_o_x      <= r_hx;
            r_o_y      <= r_hy;
            r_o_z      <= r_hz;
            r_o_lv     <= r_hlv;
        end
    end

    assign o_stat.func      = r_func;
    assign o_stat.neg       = r_qx[IN_COORD_W-1] | r_qy[IN_COORD_W-1] | r_qz[IN_COORD_W-1];
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.srch_done = srch_done;
    assign o_stat.past_end  = (n_lo >= r_count);
    assign o_stat.contain   = contain;
    assign o_stat.lo_zero   = (r_lo == '0);
    assign o_stat.out_free  = !r_o_valid || !i_stall;

    assign o_valid     = r_o_valid;
    assign o_found     = r_o_found;
    assign o_hit_index = r_o_idx;
    assign o_hit_x     = r_o_x;
    assign o_hit_y     = r_o_y;
    assign o_hit_z     = r_o_z;
    assign o_hit_level = r_o_lv;
    assign o_status    = r_o_status;

endmodule

@@ hw/rtl/morton_sorted_cell_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morton_sorted_cell_lookup
// Morton-ordered cell table with append, clear and point lookup.
// ----------------------------------------------------------------------------
// clear, append and unused codes: decode, then the result load
// query: a negative point or an empty table goes from decode to the result load, else
//   binary search steps (ceil(log2(n+1)) at most), one table read per step,
//   then one or two containment reads (none if the search ends past the last entry)
// one item at a time: the next transfer is taken in the idle state after the result load
// reset clears the entry count and control; table contents stay undefined until written
module morton_sorted_cell_lookup #(
    parameter int TABLE_DEPTH = mscl_pkg::DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = mscl_pkg::DEF_COORD_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [mscl_pkg::FUNC_W-1:0]            i_func,
    input  logic signed [mscl_pkg::IN_COORD_W-1:0] i_coord_x,
    input  logic signed [mscl_pkg::IN_COORD_W-1:0] i_coord_y,
    input  logic signed [mscl_pkg::IN_COORD_W-1:0] i_coord_z,
    input  logic [mscl_pkg::LVL_W-1:0]             i_cell_level,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_found,
    output logic [mscl_pkg::IDX_W-1:0]             o_hit_index,
    output logic [mscl_pkg::OUT_COORD_W-1:0]       o_hit_x,
    output logic [mscl_pkg::OUT_COORD_W-1:0]       o_hit_y,
    output logic [mscl_pkg::OUT_COORD_W-1:0]       o_hit_z,
    output logic [mscl_pkg::LVL_W-1:0]             o_hit_level,
    output logic                                   o_status
);
    import mscl_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign o_stall = !in_ready;

    mscl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    mscl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_func),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_cell_level (i_cell_level),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_hit_index  (o_hit_index),
        .o_hit_x      (o_hit_x),
        .o_hit_y      (o_hit_y),
        .o_hit_z      (o_hit_z),
        .o_hit_level  (o_hit_level),
        .o_status     (o_status)
    );

endmodule

@@ hw/rtl/mscl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscl_checker
// Port-level checks on the cell lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module mscl_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_stall,
    input logic                                   o_valid,
    input logic                                   i_stall,
    input logic                                   o_found,
    input logic [mscl_pkg::IDX_W-1:0]             o_hit_index,
    input logic [mscl_pkg::OUT_COORD_W-1:0]       o_hit_x,
    input logic [mscl_pkg::OUT_COORD_W-1:0]       o_hit_y,
    input logic [mscl_pkg::OUT_COORD_W-1:0]       o_hit_z,
    input logic [mscl_pkg::LVL_W-1:0]             o_hit_level,
    input logic                                   o_status
);
    import mscl_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_found) && $stable(o_hit_index)
                                  && $stable(o_status)))
        else $error("stalled result changed");

    // a transfer closes the input, checked right after the transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input open right after a transfer");

    // a hit and a refused append never come together
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> !o_status)
        else $error("found with full status");

    // a miss carries zero hit fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_hit_index == '0 && o_hit_x == '0 && o_hit_y == '0
                                   && o_hit_z == '0 && o_hit_level == '0))
        else $error("miss with nonzero hit fields");

endmodule

bind morton_sorted_cell_lookup mscl_checker u_mscl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_found     (o_found),
    .o_hit_index (o_hit_index),
    .o_hit_x     (o_hit_x),
    .o_hit_y     (o_hit_y),
    .o_hit_z     (o_hit_z),
    .o_hit_level (o_hit_level),
    .o_status    (o_status)
);

@@ tb/sv/mscl_lookup_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscl_lookup_checker
// Watches both channels of the Morton-sorted cell lookup. Each input
// transfer updates a private copy of the cell table and predicts the lookup
// result, which is queued and compared field by field with the next output
// transfer. Reports a running failure count and the number of results due.
// ----------------------------------------------------------------------------
module mscl_lookup_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic [mscl_pkg::FUNC_W-1:0]          i_func,
    input  logic [mscl_pkg::IN_COORD_W-1:0]      i_coord_x,
    input  logic [mscl_pkg::IN_COORD_W-1:0]      i_coord_y,
    input  logic [mscl_pkg::IN_COORD_W-1:0]      i_coord_z,
    input  logic [mscl_pkg::LVL_W-1:0]           i_cell_level,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic                                 i_found,
    input  logic [mscl_pkg::IDX_W-1:0]           i_hit_index,
    input  logic [mscl_pkg::OUT_COORD_W-1:0]     i_hit_x,
    input  logic [mscl_pkg::OUT_COORD_W-1:0]     i_hit_y,
    input  logic [mscl_pkg::OUT_COORD_W-1:0]     i_hit_z,
    input  logic [mscl_pkg::LVL_W-1:0]           i_hit_level,
    input  logic                                 i_status,
    output int                                   o_errors,
    output int                                   o_pending,
    output int                                   o_lookups,
    output int                                   o_hits,
    output int                                   o_refused
);

    import mscl_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;

    typedef struct packed {
        logic                   found;
        logic [IDX_W-1:0]       index;
        logic [OUT_COORD_W-1:0] x;
        logic [OUT_COORD_W-1:0] y;
        logic [OUT_COORD_W-1:0] z;
        logic [LVL_W-1:0]       level;
        logic                   status;
    } lookup_result_t;

    logic [OUT_COORD_W-1:0] tab_x [DEPTH];
    logic [OUT_COORD_W-1:0] tab_y [DEPTH];
    logic [OUT_COORD_W-1:0] tab_z [DEPTH];
    logic [LVL_W-1:0]       tab_lv[DEPTH];
    int                     cell_count = 0;
    lookup_result_t         due_results[$];

    int error_count  = 0;
    int lookup_count = 0;
    int hit_count    = 0;
    int refuse_count = 0;

    assign o_errors  = error_count;
    assign o_lookups = lookup_count;
    assign o_hits    = hit_count;
    assign o_refused = refuse_count;

    function automatic logic [MORTON_W-1:0] morton_code(logic [IN_COORD_W-1:0] x,
                                                        logic [IN_COORD_W-1:0] y,
                                                        logic [IN_COORD_W-1:0] z);
        logic [MORTON_W-1:0] m;
        m = '0;
        for (int b = 0; b < IN_COORD_W; b++) begin
            m[3*b]   = x[b];
            m[3*b+1] = y[b];
            m[3*b+2] = z[b];
        end
        return m;
    endfunction

    // both sides shifted by the coarser of the two levels
    function automatic bit cell_holds(int i, logic [IN_COORD_W-1:0] px,
                                      logic [IN_COORD_W-1:0] py,
                                      logic [IN_COORD_W-1:0] pz, logic [LVL_W-1:0] lv);
        int s;
        s = (tab_lv[i] > lv) ? tab_lv[i] : lv;
        return (({1'b0, tab_x[i]} >> s) == (px >> s)) &&
               (({1'b0, tab_y[i]} >> s) == (py >> s)) &&
               (({1'b0, tab_z[i]} >> s) == (pz >> s));
    endfunction

    function automatic lookup_result_t apply_item(logic [FUNC_W-1:0] func,
                                                  logic [IN_COORD_W-1:0] cx,
                                                  logic [IN_COORD_W-1:0] cy,
                                                  logic [IN_COORD_W-1:0] cz,
                                                  logic [LVL_W-1:0] lv);
        lookup_result_t      r;
        logic [MORTON_W-1:0] target;
        int                  lo;
        int                  hi;
        int                  mid;
        int                  hit;
        r   = '0;
        hit = -1;
        case (func)
            FUNC_CLEAR: begin
                cell_count = 0;
            end
            FUNC_APPEND: begin
                if (cell_count >= DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    tab_x[cell_count]  = cx[OUT_COORD_W-1:0];
                    tab_y[cell_count]  = cy[OUT_COORD_W-1:0];
                    tab_z[cell_count]  = cz[OUT_COORD_W-1:0];
                    tab_lv[cell_count] = lv;
                    cell_count++;
                end
            end
            FUNC_QUERY: begin
                if (!(cx[IN_COORD_W-1] | cy[IN_COORD_W-1] | cz[IN_COORD_W-1]) &&
                    cell_count > 0) begin
                    target = morton_code(cx, cy, cz);
                    lo = 0;
                    hi = cell_count;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (morton_code({1'b0, tab_x[mid]}, {1'b0, tab_y[mid]},
                                        {1'b0, tab_z[mid]}) < target) begin
                            lo = mid + 1;
                        end else begin
                            hi = mid;
                        end
                    end
                    if (lo < cell_count) begin
                        if (cell_holds(lo, cx, cy, cz, lv)) begin
                            hit = lo;
                        end else if (lo > 0 && cell_holds(lo - 1, cx, cy, cz, lv)) begin
                            hit = lo - 1;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (hit >= 0) begin
            r.found = 1'b1;
            r.index = hit[IDX_W-1:0];
            r.x     = tab_x[hit];
            r.y     = tab_y[hit];
            r.z     = tab_z[hit];
            r.level = tab_lv[hit];
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v,
                                        logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch_channels
        lookup_result_t want;
        lookup_result_t got;
        if (!i_rst_n) begin
            cell_count = 0;
            due_results.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                want = apply_item(i_func, i_coord_x, i_coord_y, i_coord_z, i_cell_level);
                due_results.push_back(want);
                if (i_func == FUNC_QUERY) begin
                    lookup_count++;
                end
                if (want.found) begin
                    hit_count++;
                end
                if (want.status) begin
                    refuse_count++;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with no lookup outstanding");
                    error_count++;
                end else begin
                    want = due_results.pop_front();
                    got  = '{i_found, i_hit_index, i_hit_x, i_hit_y, i_hit_z,
                             i_hit_level, i_status};
                    check_field("found", 32'(want.found), 32'(got.found));
                    check_field("hit_index", 32'(want.index), 32'(got.index));
                    check_field("hit_x", 32'(want.x), 32'(got.x));
                    check_field("hit_y", 32'(want.y), 32'(got.y));
                    check_field("hit_z", 32'(want.z), 32'(got.z));
                    check_field("hit_level", 32'(want.level), 32'(got.level));
                    check_field("status", 32'(want.status), 32'(got.status));
                end
            end
            o_pending <= due_results.size();
        end
    end

endmodule

@@ tb/sv/tb_morton_sorted_cell_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morton_sorted_cell_lookup
// Drives the cell lookup with a directed set of corner cases, then with
// random scenes: Morton-ordered appends followed by point lookups near their
// cells, one fill of the whole table past its capacity, and raw noise.
// Handshakes idle at random until the last third; the checker judges results.
// ----------------------------------------------------------------------------
module tb_morton_sorted_cell_lookup;

    import mscl_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS    = 1300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DEPTH          = DEF_TABLE_DEPTH;
    localparam int CODE_MAX       = 32'h3fff_ffff;

    logic                          i_clk;
    logic                          i_rst_n      = 1'b0;
    logic                          i_valid      = 1'b0;
    logic                          o_stall;
    logic [FUNC_W-1:0]             i_func       = FUNC_CLEAR;
    logic signed [IN_COORD_W-1:0]  i_coord_x    = '0;
    logic signed [IN_COORD_W-1:0]  i_coord_y    = '0;
    logic signed [IN_COORD_W-1:0]  i_coord_z    = '0;
    logic [LVL_W-1:0]              i_cell_level = '0;
    logic                          o_valid;
    logic                          i_stall      = 1'b0;
    logic                          o_found;
    logic [IDX_W-1:0]              o_hit_index;
    logic [OUT_COORD_W-1:0]        o_hit_x;
    logic [OUT_COORD_W-1:0]        o_hit_y;
    logic [OUT_COORD_W-1:0]        o_hit_z;
    logic [LVL_W-1:0]              o_hit_level;
    logic                          o_status;

    int fail_count;
    int due_count;
    int lookup_count;
    int hit_count;
    int refuse_count;

    int items_sent    = 0;
    int send_idle_pct = 25;
    int recv_idle_pct = 55;
    int stuck_cycles  = 0;
    bit table_filled  = 1'b0;

    int sc_x[$];
    int sc_y[$];
    int sc_z[$];
    int sc_lv[$];

    morton_sorted_cell_lookup DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_cell_level (i_cell_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_found      (o_found),
        .o_hit_index  (o_hit_index),
        .o_hit_x      (o_hit_x),
        .o_hit_y      (o_hit_y),
        .o_hit_z      (o_hit_z),
        .o_hit_level  (o_hit_level),
        .o_status     (o_status)
    );

    mscl_lookup_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_func       (i_func),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .i_cell_level (i_cell_level),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_found      (o_found),
        .i_hit_index  (o_hit_index),
        .i_hit_x      (o_hit_x),
        .i_hit_y      (o_hit_y),
        .i_hit_z      (o_hit_z),
        .i_hit_level  (o_hit_level),
        .i_status     (o_status),
        .o_errors     (fail_count),
        .o_pending    (due_count),
        .o_lookups    (lookup_count),
        .o_hits       (hit_count),
        .o_refused    (refuse_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input int x, input int y,
                             input int z, input int lv);
        if (items_sent < TOTAL_ITEMS / 3) begin
            send_idle_pct = 25;
            recv_idle_pct = 55;
        end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
            send_idle_pct = 55;
            recv_idle_pct = 25;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= f;
        i_coord_x    <= x[IN_COORD_W-1:0];
        i_coord_y    <= y[IN_COORD_W-1:0];
        i_coord_z    <= z[IN_COORD_W-1:0];
        i_cell_level <= lv[LVL_W-1:0];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain_results;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
    endtask

    // corners in non-decreasing morton order by running code plus random gaps
    task automatic build_table(input int n, input bit do_clear);
        longint code;
        longint gap;
        int     x;
        int     y;
        int     z;
        int     lv;
        code = 0;
        gap  = (longint'(1) << 31) / n;
        if (do_clear) begin
            send_item(FUNC_CLEAR, 0, 0, 0, 0);
            sc_x.delete();
            sc_y.delete();
            sc_z.delete();
            sc_lv.delete();
        end
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) != 0) begin
                code += $urandom_range(0, int'(gap));
            end
            if (code > CODE_MAX) begin
                code = CODE_MAX;
            end
            x = 0;
            y = 0;
            z = 0;
            for (int b = 0; b < OUT_COORD_W; b++) begin
                x[b] = code[3*b];
                y[b] = code[3*b+1];
                z[b] = code[3*b+2];
            end
            lv = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 4);
            send_item(FUNC_APPEND, x, y, z, lv);
            sc_x.push_back(x);
            sc_y.push_back(y);
            sc_z.push_back(z);
            sc_lv.push_back(lv);
        end
    endtask

    task automatic ask_queries(input int n);
        int k;
        int m;
        int px;
        int py;
        int pz;
        int qlv;
        int sel;
        for (int q = 0; q < n; q++) begin
            k   = $urandom_range(0, sc_x.size() - 1);
            m   = (1 << ((sc_lv[k] > 10) ? 10 : sc_lv[k])) - 1;
            sel = $urandom_range(0, 9);
            px  = sc_x[k];
            py  = sc_y[k];
            pz  = sc_z[k];
            qlv = 0;
            if (sel <= 5) begin
                px  = (px & ~m) | ($urandom_range(0, 1023) & m);
                py  = (py & ~m) | ($urandom_range(0, 1023) & m);
                pz  = (pz & ~m) | ($urandom_range(0, 1023) & m);
                qlv = $urandom_range(0, 3);
            end else if (sel == 7) begin
                px  = $urandom_range(0, 1023);
                py  = $urandom_range(0, 1023);
                pz  = $urandom_range(0, 1023);
                qlv = $urandom_range(0, 15);
            end else if (sel == 8) begin
                case ($urandom_range(0, 2))
                    0: px = -$urandom_range(1, 1024);
                    1: py = -$urandom_range(1, 1024);
                    default: pz = -$urandom_range(1, 1024);
                endcase
            end else if (sel == 9) begin
                qlv = $urandom_range(0, 15);
            end
            send_item(FUNC_QUERY, px, py, pz, qlv);
        end
    endtask

    task automatic send_noise;
        repeat ($urandom_range(4, 12)) begin
            send_item(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, 15));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, unused code, then a small sorted table
        send_item(FUNC_QUERY, 5, 5, 5, 0);
        send_item(FUNC_UNUSED, -1, -1, -1, 15);
        send_item(FUNC_CLEAR, 0, 0, 0, 0);
        send_item(FUNC_APPEND, 0, 0, 0, 0);
        send_item(FUNC_APPEND, 2, 2, 2, 1);
        send_item(FUNC_APPEND, 4, 0, 0, 2);
        send_item(FUNC_APPEND, 512, 0, 0, 10);
        send_item(FUNC_QUERY, 1000, 1000, 1000, 0);
        send_item(FUNC_APPEND, 1023, 1023, 1023, 0);
        send_item(FUNC_APPEND, -1, -1, -1, 15);
        send_item(FUNC_QUERY, 0, 0, 0, 0);
        send_item(FUNC_QUERY, 3, 3, 3, 0);
        send_item(FUNC_QUERY, 1, 0, 0, 0);
        send_item(FUNC_QUERY, 1, 0, 0, 1);
        send_item(FUNC_QUERY, 700, 5, 3, 0);
        send_item(FUNC_QUERY, 1023, 1023, 1023, 0);
        send_item(FUNC_QUERY, -1024, 1023, 0, 0);
        send_item(FUNC_QUERY, 0, -1, 0, 0);
        send_item(FUNC_QUERY, 5, 5, 5, 15);
        // wrapped corner lands out of order
        send_item(FUNC_APPEND, -1024, -1024, -1024, 0);
        send_item(FUNC_QUERY, 0, 0, 0, 0);
        send_item(FUNC_QUERY, 1023, 0, 1023, 3);
        send_item(FUNC_CLEAR, 0, 0, 0, 0);

        while (items_sent < TOTAL_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                drain_results();
            end
            if (!table_filled && items_sent >= 150) begin
                drain_results();
                build_table(DEPTH, 1'b1);
                send_item(FUNC_APPEND, 1023, 1023, 1023, 15);
                send_item(FUNC_APPEND, -1024, 0, -1, 0);
                send_item(FUNC_APPEND, $urandom_range(0, 2047), $urandom_range(0, 2047),
                          $urandom_range(0, 2047), $urandom_range(0, 15));
                ask_queries(40);
                table_filled = 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                send_noise();
            end else begin
                build_table($urandom_range(1, 40), $urandom_range(0, 5) != 0);
                ask_queries($urandom_range(4, 20));
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("%0d transfers: %0d lookups, %0d hits, %0d appends refused on a full table",
                 items_sent, lookup_count, hit_count, refuse_count);
        $display("sorted, unsorted and overflowing tables under three idle mixes");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
